// ===== rtl/tbs_pkg.sv =====
package tbs_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int BYTE_SHIFT    = 3;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TOK_W   = 32 + FRACTION_BITS;
    localparam int CMD_AW  = 1;
    localparam int CMD_DEPTH = 1 << CMD_AW;

    typedef enum logic [2:0] {
        REG_SHAPED_FLOW   = 3'd0,
        REG_SHAPER_ACTIVE = 3'd1,
        REG_TOKEN_RATE    = 3'd2,
        REG_BUCKET_DEPTH  = 3'd3,
        REG_QUEUE_LIMIT   = 3'd4,
        REG_FLOW_PRIORITY = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_ARRIVAL = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ACT_FORWARD = 3'd0,
        ACT_DROP    = 3'd1,
        ACT_QUEUE   = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_BYPASS  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CMD_BYPASS,
        CMD_ARRIVE,
        CMD_TICK
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ARRIVE,
        ST_TICK_ADD,
        ST_TICK_CHECK
    } state_t;

    typedef struct packed {
        logic [15:0] shaped_flow;
        logic        shaper_active;
        logic [31:0] token_rate;
        logic [31:0] bucket_depth;
        logic [4:0]  queue_limit;
        logic [7:0]  flow_priority;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] size;
        logic [15:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] size;
    } q_entry_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] r;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = ptr + 1'b1;
        return r;
    endfunction

    function automatic logic [TOK_W-1:0] cost_of(input logic [15:0] size);
        return TOK_W'(size) << (BYTE_SHIFT + FRACTION_BITS);
    endfunction

endpackage

// ===== rtl/tbs_front.sv =====
module tbs_front
    import tbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] flow_number,
    input  logic [15:0] size_bytes,
    input  logic [15:0] tag_in,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]   cnt_reg, cnt_next;
    cmd_t              new_cmd;
    logic              push;

    // classify
    always_comb
    begin
        new_cmd.size = size_bytes;
        new_cmd.tag  = tag_in;
        case (op_t'(operation))
            OP_TICK:
                new_cmd.kind = CMD_TICK;
            OP_ARRIVAL:
                new_cmd.kind = (cfg.shaper_active && flow_number == cfg.shaped_flow)
                               ? CMD_ARRIVE : CMD_BYPASS;
            default:
                new_cmd.kind = CMD_BYPASS;
        endcase
    end

    assign in_ready  = (cnt_reg != (CMD_AW+1)'(CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !cmd_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && cmd_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

// ===== rtl/tbs_back.sv =====
module tbs_back
    import tbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [15:0] tag_out,
    output logic [15:0] size_out,
    output logic [7:0]  priority_out,
    output logic        last
);

    state_t            state_reg, state_next;
    logic [TOK_W-1:0]  tok_reg, tok_next;
    logic              started_reg, started_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    q_entry_t          q_mem [QUEUE_DEPTH];
    logic              q_we;
    logic [15:0]       cur_tag_reg, cur_tag_next;
    logic [15:0]       cur_size_reg, cur_size_next;
    logic              held_valid_reg, held_valid_next;
    q_entry_t          held_reg, held_next;

    logic              out_valid_reg;
    action_t           res_action_reg, res_action;
    logic [15:0]       res_tag_reg, res_tag;
    logic [15:0]       res_size_reg, res_size;
    logic [7:0]        res_prio_reg, res_prio;
    logic              res_last_reg, res_last;
    logic              res_load;

    logic [TOK_W-1:0]  cap;
    logic [TOK_W:0]    tick_sum;
    logic [TOK_W-1:0]  tick_capped;
    q_entry_t          head_e;
    logic [TOK_W-1:0]  head_cost;
    logic [TOK_W-1:0]  cur_cost;
    logic              can_rel;
    logic              out_free;
    logic [CNT_W-1:0]  lim;

    always_comb
    begin
        cap         = TOK_W'(cfg.bucket_depth) << FRACTION_BITS;
        tick_sum    = (TOK_W+1)'(tok_reg) + (TOK_W+1)'(cfg.token_rate);
        tick_capped = (tick_sum > (TOK_W+1)'(cap)) ? cap : tick_sum[TOK_W-1:0];
        head_e      = q_mem[head_reg];
        head_cost   = cost_of(head_e.size);
        cur_cost    = cost_of(cur_size_reg);
        can_rel     = (cnt_reg != '0) && (tok_reg >= head_cost);
        out_free    = !out_valid_reg || out_ready;
        if (32'(cfg.queue_limit) >= 32'(QUEUE_DEPTH))
            lim = CNT_W'(QUEUE_DEPTH);
        else
            lim = CNT_W'(cfg.queue_limit);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_ARRIVE: state_next = ST_PREP;
                        CMD_TICK:   state_next = ST_TICK_ADD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_PREP:
                state_next = ST_ARRIVE;
            ST_ARRIVE:
                if (out_free)
                    state_next = ST_IDLE;
            ST_TICK_ADD:
                state_next = ST_TICK_CHECK;
            ST_TICK_CHECK:
                if (!can_rel && (!held_valid_reg || out_free))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_pop         = 1'b0;
        res_load        = 1'b0;
        res_action      = ACT_BYPASS;
        res_tag         = '0;
        res_size        = '0;
        res_prio        = '0;
        res_last        = 1'b1;
        q_we            = 1'b0;
        tok_next        = tok_reg;
        started_next    = started_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        cur_tag_next    = cur_tag_reg;
        cur_size_next   = cur_size_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_BYPASS:
                            if (out_free)
                            begin
                                cmd_pop    = 1'b1;
                                res_load   = 1'b1;
                                res_action = ACT_BYPASS;
                                res_tag    = cmd.tag;
                                res_size   = cmd.size;
                            end
                        CMD_ARRIVE:
                        begin
                            cmd_pop       = 1'b1;
                            cur_tag_next  = cmd.tag;
                            cur_size_next = cmd.size;
                        end
                        CMD_TICK:
                            cmd_pop = 1'b1;
                        default:
                            cmd_pop = 1'b1;
                    endcase
                end
            ST_PREP:
                if (!started_reg)
                begin
                    tok_next     = cap;
                    started_next = 1'b1;
                end
                else if (cnt_reg == '0 && tok_reg > cap)
                    tok_next = cap;
            ST_ARRIVE:
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_tag  = cur_tag_reg;
                    res_size = cur_size_reg;
                    res_prio = cfg.flow_priority;
                    if (cnt_reg != '0)
                    begin
                        if (cnt_reg < lim)
                        begin
                            q_we       = 1'b1;
                            res_action = ACT_QUEUE;
                        end
                        else
                            res_action = ACT_DROP;
                    end
                    else if (tok_reg >= cur_cost)
                    begin
                        tok_next   = tok_reg - cur_cost;
                        res_action = ACT_FORWARD;
                    end
                    else if (lim != '0)
                    begin
                        q_we       = 1'b1;
                        res_action = ACT_QUEUE;
                    end
                    else
                        res_action = ACT_DROP;
                    if (q_we)
                    begin
                        tail_next = next_ptr(tail_reg);
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
            ST_TICK_ADD:
                tok_next = tick_capped;
            ST_TICK_CHECK:
            begin
                res_action = ACT_RELEASE;
                res_tag    = held_reg.tag;
                res_size   = held_reg.size;
                res_prio   = cfg.flow_priority;
                if (can_rel)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        // emit the held release, it is not the final one
                        res_load        = held_valid_reg;
                        res_last        = 1'b0;
                        held_next       = head_e;
                        held_valid_next = 1'b1;
                        tok_next        = tok_reg - head_cost;
                        head_next       = next_ptr(head_reg);
                        cnt_next        = cnt_reg - 1'b1;
                    end
                end
                else if (held_valid_reg && out_free)
                begin
                    res_load        = 1'b1;
                    res_last        = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default:
                cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tok_reg        <= '0;
            started_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tok_reg        <= tok_next;
            started_reg    <= started_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_tag_reg  <= cur_tag_next;
        cur_size_reg <= cur_size_next;
        held_reg     <= held_next;
        if (q_we)
            q_mem[tail_reg] <= '{tag: cur_tag_reg, size: cur_size_reg};
        if (res_load)
        begin
            res_action_reg <= res_action;
            res_tag_reg    <= res_tag;
            res_size_reg   <= res_size;
            res_prio_reg   <= res_prio;
            res_last_reg   <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = res_action_reg;
    assign tag_out      = res_tag_reg;
    assign size_out     = res_size_reg;
    assign priority_out = res_prio_reg;
    assign last         = res_last_reg;

    a_held_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> state_reg == ST_TICK_CHECK)
        else $error("held release outside tick drain");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with unequal pointers");

    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_action == ACT_QUEUE) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queued item not counted");

    a_tok_capped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK_CHECK |-> tok_reg <= cap)
        else $error("tokens above bucket depth during drain");

endmodule

// ===== rtl/token_bucket_shaper_unit.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    operation, flow_number, size_bytes, tag_in
// out       out_valid / out_ready  action, tag_out, size_out, priority_out, last
// cfg       cfg_write              cfg_index, cfg_data
//
// Bypassed arrivals go out from idle; shaped ones pass fetch, bucket cap and decide.
// A tick adds tokens up to bucket depth, then releases queued items while tokens cover
// the head, the final release marked last; the back-end state machine runs these steps.
// A two-entry command queue lets inputs be taken while the back end works.
// Reset clears tokens, queue pointers and configuration; queue storage is not cleared.
// A stalled output holds the back end; the front keeps accepting until its queue fills.
module token_bucket_shaper_unit
    import tbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] flow_number,
    input  logic [15:0] size_bytes,
    input  logic [15:0] tag_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [15:0] tag_out,
    output logic [15:0] size_out,
    output logic [7:0]  priority_out,
    output logic        last,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_SHAPED_FLOW:   cfg_reg.shaped_flow   <= cfg_data[15:0];
                REG_SHAPER_ACTIVE: cfg_reg.shaper_active <= cfg_data[0];
                REG_TOKEN_RATE:    cfg_reg.token_rate    <= cfg_data;
                REG_BUCKET_DEPTH:  cfg_reg.bucket_depth  <= cfg_data;
                REG_QUEUE_LIMIT:   cfg_reg.queue_limit   <= cfg_data[4:0];
                REG_FLOW_PRIORITY: cfg_reg.flow_priority <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    tbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .flow_number (flow_number),
        .size_bytes  (size_bytes),
        .tag_in      (tag_in),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    tbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .tag_out      (tag_out),
        .size_out     (size_out),
        .priority_out (priority_out),
        .last         (last)
    );

endmodule
